>>> hdl/btls_pkg.sv
package btls_pkg;

  // Field widths
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned THR_W      = 13;
  localparam int unsigned DEB_W      = 8;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SECS_W     = 7;
  localparam int unsigned LAMP_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [DUR_W-1:0] RED_TIME_RST    = 16'd2000;
  localparam logic [DUR_W-1:0] YELLOW_TIME_RST = 16'd3000;
  localparam logic [DUR_W-1:0] GREEN_TIME_RST  = 16'd5000;
  localparam logic [DUR_W-1:0] BLINK_RST       = 16'd200;
  localparam logic [THR_W-1:0] DARK_RST        = 13'd1800;
  localparam logic [DEB_W-1:0] DEBOUNCE_RST    = 8'd35;

  // Countdown timing
  localparam int unsigned REFRESH_MS  = 200;
  localparam int unsigned ROUND_UP_MS = 999;
  localparam int unsigned MS_PER_S    = 1000;

  // Divide by MS_PER_S as multiply by reciprocal; exact for numerators below 2^17
  localparam int unsigned NUM_W       = DUR_W + 1;
  localparam int unsigned RECIP_SHIFT = 37;
  localparam int unsigned RECIP_W     = 28;
  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S));

  // Lamp drive codes: bit 0 red, bit 1 yellow, bit 2 green
  localparam logic [LAMP_W-1:0] LAMP_OFF    = 3'b000;
  localparam logic [LAMP_W-1:0] LAMP_RED    = 3'b001;
  localparam logic [LAMP_W-1:0] LAMP_YELLOW = 3'b010;
  localparam logic [LAMP_W-1:0] LAMP_GREEN  = 3'b100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_TIME    = 3'd0,
    REG_YELLOW_TIME = 3'd1,
    REG_GREEN_TIME  = 3'd2,
    REG_BLINK       = 3'd3,
    REG_DARK        = 3'd4,
    REG_DEBOUNCE    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_RED    = 2'd0,
    PH_YELLOW = 2'd1,
    PH_GREEN  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [DUR_W-1:0] red_time;
    logic [DUR_W-1:0] yellow_time;
    logic [DUR_W-1:0] green_time;
    logic [DUR_W-1:0] blink_period;
    logic [THR_W-1:0] dark_threshold;
    logic [DEB_W-1:0] debounce;
  } cfg_t;

  typedef struct packed {
    logic                button_level;
    logic [SAMPLE_W-1:0] light_sample;
  } tick_t;

  typedef struct packed {
    logic              red_on;
    logic              yellow_on;
    logic              green_on;
    logic              street_on;
    logic              display_on;
    logic              show_update;
    logic              show_blank;
    logic [SECS_W-1:0] seconds_left;
  } result_t;

endpackage

>>> hdl/btls_if.sv
// Tick channel: one beat per millisecond tick
interface btls_tick_if
  import btls_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                button_level;
  logic [SAMPLE_W-1:0] light_sample;

  modport source (output valid, button_level, light_sample, input ready);
  modport sink   (input valid, button_level, light_sample, output ready);
endinterface

// Result channel: one beat per tick
interface btls_result_if
  import btls_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              red_on;
  logic              yellow_on;
  logic              green_on;
  logic              street_on;
  logic              display_on;
  logic              show_update;
  logic              show_blank;
  logic [SECS_W-1:0] seconds_left;

  modport source (output valid, red_on, yellow_on, green_on, street_on, display_on,
                  show_update, show_blank, seconds_left, input ready);
  modport sink   (input valid, red_on, yellow_on, green_on, street_on, display_on,
                  show_update, show_blank, seconds_left, output ready);
endinterface

// Register write channel
interface btls_cfg_if
  import btls_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/btls_step.sv
module btls_step
  import btls_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  tick_t   tick,
  input  cfg_t    cfg,
  output result_t res
);

  // Sequencer state
  logic [TIME_BITS-1:0] time_now;
  logic [TIME_BITS-1:0] phase_start;
  logic [TIME_BITS-1:0] last_blink_time;
  logic [TIME_BITS-1:0] last_refresh_time;
  logic [TIME_BITS-1:0] level_change_time;
  phase_t               phase;
  phase_t               phase_next;
  logic                 blink_level;
  logic                 shown_valid;
  logic [SECS_W-1:0]    shown_value;
  logic                 display_enable;
  logic                 raw_level_seen;
  logic                 stable_level;
  logic [LAMP_W-1:0]    lamp_levels;

  logic [TIME_BITS-1:0] t_next;
  logic [TIME_BITS-1:0] since_level;
  logic [TIME_BITS-1:0] since_blink;
  logic [TIME_BITS-1:0] since_refresh;
  logic [TIME_BITS-1:0] elapsed;
  logic                 raw_change;
  logic                 deb_ok;
  logic                 press;
  logic                 disp_new;
  logic                 street;
  logic                 blink_fire;
  logic [LAMP_W-1:0]    active_lamp;
  logic [LAMP_W-1:0]    lamps_new;
  logic                 refresh_due;
  logic [DUR_W-1:0]     dur;
  logic                 phase_done;
  logic [DUR_W-1:0]     remain;
  logic [NUM_W-1:0]     numer;
  logic [NUM_W+RECIP_W-1:0] prod;
  logic [SECS_W-1:0]    secs;
  logic                 shown_valid_p;
  logic                 upd;

  // Time differences, all modulo 2^TIME_BITS
  assign t_next        = time_now + 1'b1;
  assign since_level   = t_next - level_change_time;
  assign since_blink   = t_next - last_blink_time;
  assign since_refresh = t_next - last_refresh_time;
  assign elapsed       = t_next - phase_start;

  // Debounce: a level seen changing this tick has held for zero ms
  assign raw_change = tick.button_level != raw_level_seen;
  assign deb_ok     = !raw_change && (since_level > TIME_BITS'(cfg.debounce)) &&
                      (tick.button_level != stable_level);
  assign press      = deb_ok && !tick.button_level;
  assign disp_new   = display_enable ^ press;

  assign street = {1'b0, tick.light_sample} < cfg.dark_threshold;

  // Active lamp and phase length; unused code acts as red
  always_comb begin
    case (phase)
      PH_YELLOW: begin
        active_lamp = LAMP_YELLOW;
        dur         = cfg.yellow_time;
      end
      PH_GREEN: begin
        active_lamp = LAMP_GREEN;
        dur         = cfg.green_time;
      end
      default: begin
        active_lamp = LAMP_RED;
        dur         = cfg.red_time;
      end
    endcase
  end

  // Blink
  assign blink_fire = since_blink >= TIME_BITS'(cfg.blink_period);
  assign lamps_new  = blink_fire ? (!blink_level ? active_lamp : LAMP_OFF) : lamp_levels;

  // Countdown: ceil(remain / 1000) via reciprocal multiply
  assign phase_done  = elapsed >= TIME_BITS'(dur);
  assign remain      = phase_done ? '0 : dur - elapsed[DUR_W-1:0];
  assign numer       = {1'b0, remain} + NUM_W'(ROUND_UP_MS);
  assign prod        = (NUM_W+RECIP_W)'(numer) * (NUM_W+RECIP_W)'(RECIP_MUL);
  assign secs        = prod[RECIP_SHIFT +: SECS_W];
  assign refresh_due = disp_new && (since_refresh >= TIME_BITS'(REFRESH_MS));

  // A press drops the shown value before the refresh looks at it
  assign shown_valid_p = shown_valid && !press;
  assign upd           = refresh_due && (!shown_valid_p || (secs != shown_value));

  // Phase next state
  always_comb begin
    phase_next = phase;
    if (phase_done) begin
      case (phase)
        PH_RED:    phase_next = PH_YELLOW;
        PH_YELLOW: phase_next = PH_GREEN;
        default:   phase_next = PH_RED;
      endcase
    end
  end

  // Result for this tick
  always_comb begin
    res.red_on       = lamps_new[0];
    res.yellow_on    = lamps_new[1];
    res.green_on     = lamps_new[2];
    res.street_on    = street;
    res.display_on   = disp_new;
    res.show_update  = upd;
    res.show_blank   = !disp_new;
    res.seconds_left = upd ? secs : '0;
  end

  // State update, one tick per enable
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now          <= '0;
      phase             <= PH_RED;
      phase_start       <= '0;
      last_blink_time   <= '0;
      blink_level       <= 1'b0;
      last_refresh_time <= '0;
      shown_valid       <= 1'b0;
      shown_value       <= '0;
      display_enable    <= 1'b1;
      raw_level_seen    <= 1'b1;
      stable_level      <= 1'b1;
      level_change_time <= '0;
      lamp_levels       <= LAMP_OFF;
    end else if (en) begin
      time_now       <= t_next;
      raw_level_seen <= tick.button_level;
      display_enable <= disp_new;
      lamp_levels    <= lamps_new;
      phase          <= phase_next;
      if (raw_change) begin
        level_change_time <= t_next;
      end
      if (deb_ok) begin
        stable_level <= tick.button_level;
      end
      if (refresh_due) begin
        last_refresh_time <= t_next;
      end
      if (upd) begin
        shown_value <= secs;
      end
      if (phase_done) begin
        phase_start     <= t_next;
        blink_level     <= 1'b0;
        last_blink_time <= '0;
        shown_valid     <= 1'b0;
      end else begin
        shown_valid <= upd | shown_valid_p;
        if (blink_fire) begin
          blink_level     <= !blink_level;
          last_blink_time <= t_next;
        end
      end
    end
  end

endmodule

>>> hdl/blinking_traffic_light_sequencer.sv
// Path: a tick beat accepted into the tick input register goes through the step logic to the result register.
// Throughput: one tick per cycle while the result register is free or draining; the single pass
// from the tick register through the step logic (one 17x28 multiply) to the result register sets it.
// Reset (rst, synchronous, active high) loads register defaults, clears both
// stage valids and returns the sequencer to red with the display enabled.
module blinking_traffic_light_sequencer
  import btls_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input logic           clk,
  input logic           rst,
  btls_tick_if.sink     tick,
  btls_result_if.source result,
  btls_cfg_if.sink      cfg
);

  cfg_t    cfg_regs;
  tick_t   tick_data;
  logic    tick_valid;
  result_t step_res;
  result_t out_data;
  logic    out_valid;
  logic    step_go;

  // Register writes, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.red_time       <= RED_TIME_RST;
      cfg_regs.yellow_time    <= YELLOW_TIME_RST;
      cfg_regs.green_time     <= GREEN_TIME_RST;
      cfg_regs.blink_period   <= BLINK_RST;
      cfg_regs.dark_threshold <= DARK_RST;
      cfg_regs.debounce       <= DEBOUNCE_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_RED_TIME:    cfg_regs.red_time       <= cfg.data;
        REG_YELLOW_TIME: cfg_regs.yellow_time    <= cfg.data;
        REG_GREEN_TIME:  cfg_regs.green_time     <= cfg.data;
        REG_BLINK:       cfg_regs.blink_period   <= cfg.data;
        REG_DARK:        cfg_regs.dark_threshold <= cfg.data[THR_W-1:0];
        REG_DEBOUNCE:    cfg_regs.debounce       <= cfg.data[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // Step advances when the result register is free or draining
  assign step_go    = tick_valid && (!out_valid || result.ready);
  assign tick.ready = !tick_valid || step_go;

  // Tick input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      tick_valid <= 1'b1;
    end else if (step_go) begin
      tick_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      tick_data.button_level <= tick.button_level;
      tick_data.light_sample <= tick.light_sample;
    end
  end

  btls_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .clk  (clk),
    .rst  (rst),
    .en   (step_go),
    .tick (tick_data),
    .cfg  (cfg_regs),
    .res  (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_data <= step_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.red_on       = out_data.red_on;
  assign result.yellow_on    = out_data.yellow_on;
  assign result.green_on     = out_data.green_on;
  assign result.street_on    = out_data.street_on;
  assign result.display_on   = out_data.display_on;
  assign result.show_update  = out_data.show_update;
  assign result.show_blank   = out_data.show_blank;
  assign result.seconds_left = out_data.seconds_left;

`ifndef SYNTH
  // Blank beats go with the display off, updates with it on
  a_blank_matches_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.show_blank == !out_data.display_on))
    else $error("show_blank disagrees with display_on");

  a_update_not_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.show_update && out_data.show_blank))
    else $error("update and blank in one beat");

  a_one_lamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({out_data.red_on, out_data.yellow_on, out_data.green_on}))
    else $error("more than one traffic lamp on");

  a_secs_only_on_update: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.show_update) |-> (out_data.seconds_left == '0))
    else $error("seconds_left nonzero without update");

  a_tick_held: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && !step_go) |=> (tick_valid && $stable(tick_data)))
    else $error("stalled tick lost from input register");
`endif

endmodule
